// ===== hw/rtl/shared_port_priority_switcher_top_assert.svh =====
// assertion macros for the shared port priority switcher
// expects signals named clock and reset in the including module
`ifndef SHARED_PORT_PRIORITY_SWITCHER_TOP_ASSERT_SVH
`define SHARED_PORT_PRIORITY_SWITCHER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SPS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SPS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/sps_pkg.sv =====
// shared definitions for the shared port priority switcher
// opcodes, field widths and reset constants; no dependencies
package sps_pkg;

   localparam int OPCODE_W = 3;
   localparam int DEV_W    = 4;
   localparam int SPEED_W  = 24;
   localparam int PRIO_W   = 8;
   localparam int TIME_W   = 20;
   localparam int GUARD_W  = 22;
   localparam int CUR_W    = 5;

   localparam int SLOT_COUNT_DEFAULT = 16;

   localparam logic [OPCODE_W-1:0] OP_REGISTER  = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_SET_SPEED = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_SET_PRIO  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_SET_INTR  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_TICK      = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_QUERY     = 3'd5;

   localparam logic [TIME_W-1:0]  GUARD_RESET_US = 20'd50000;
   localparam logic [SPEED_W-1:0] SPEED_RESET    = 24'd9600;

endpackage

// ===== hw/rtl/shared_port_priority_switcher_top.sv =====
// shared port priority switcher, single module
// depends on sps_pkg and shared_port_priority_switcher_top_assert.svh
`include "shared_port_priority_switcher_top_assert.svh"
// usage
//   req_* channel: one operation per transfer (register, set speed, set
//   priority, set interruptible, tick, query). req_stall is high while an
//   operation is being worked on; a new transfer is taken only when idle.
//   rsp_* channel: exactly one result per operation, held in an output
//   register until the receiver takes it. while rsp_stall holds a result,
//   the next operation is still accepted and worked on; it waits at the
//   end for the output register to free up.
//   csr_* channel: guard time in microseconds, always ready.
//   steps: a tick makes up to three slot passes (switching/owner pass,
//   priority pass through the priority memory, lowest-owner pass); every
//   other operation makes the lowest-owner pass, set speed after a read
//   and compare in the speed memory.
//   throughput: the next transfer is taken only after the result is
//   loaded, so one operation is worked on at a time.
//   the pace is set by the one shared slot scanner, which visits one slot
//   per cycle, and by the registered read port of the slot memories.
//   reset: all slots unregistered, interruptible, 9600 baud, priority 0,
//   guard countdown and guard time 50000 us; no clearing pass is needed.
//
module shared_port_priority_switcher_top
   import sps_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // operation channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [OPCODE_W-1:0]       req_opcode,
   input  logic [DEV_W-1:0]          req_device,
   input  logic [SPEED_W-1:0]        req_speed,
   input  logic [PRIO_W-1:0]         req_priority_req,
   input  logic                      req_interruptible,
   input  logic [TIME_W-1:0]         req_delta_us,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_mux_select_valid,
   output logic [DEV_W-1:0]          rsp_mux_select_device,
   output logic                      rsp_speed_set_valid,
   output logic [SPEED_W-1:0]        rsp_speed_value,
   output logic signed [CUR_W-1:0]   rsp_current_device,
   output logic                      rsp_queried_current,
   output logic                      rsp_queried_switching,
   // guard time register
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [TIME_W-1:0]         csr_data
);

   localparam int SW = $clog2(SLOT_COUNT);
   localparam int CW = $clog2(SLOT_COUNT + 1);
   localparam int LW = (CW > DEV_W) ? CW : DEV_W;
   localparam logic [CW-1:0] LAST_CNT = CW'(SLOT_COUNT - 1);
   localparam logic [CW-1:0] END_CNT  = CW'(SLOT_COUNT);
   localparam logic [LW-1:0] SLOT_LIM = LW'(SLOT_COUNT);

   // sequencer states
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_EXEC    = 4'd1;
   localparam logic [3:0] ST_SSCAN   = 4'd2;
   localparam logic [3:0] ST_STICK   = 4'd3;
   localparam logic [3:0] ST_PLOAD   = 4'd4;
   localparam logic [3:0] ST_PSCAN   = 4'd5;
   localparam logic [3:0] ST_PDECIDE = 4'd6;
   localparam logic [3:0] ST_PEMIT   = 4'd7;
   localparam logic [3:0] ST_SRD     = 4'd8;
   localparam logic [3:0] ST_SCMP    = 4'd9;
   localparam logic [3:0] ST_FIND    = 4'd10;
   localparam logic [3:0] ST_RESP    = 4'd11;

   // control state
   logic [3:0]              state_ff, state_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [SLOT_COUNT-1:0]   valid_ff, valid_in;
   logic [SLOT_COUNT-1:0]   owner_ff, owner_in;
   logic [SLOT_COUNT-1:0]   switching_ff, switching_in;
   logic [SLOT_COUNT-1:0]   preempt_ff, preempt_in;
   logic [SLOT_COUNT-1:0]   prio_set_ff, prio_set_in;
   logic [SLOT_COUNT-1:0]   spd_set_ff, spd_set_in;
   logic signed [GUARD_W-1:0] guard_ff, guard_in;
   logic [TIME_W-1:0]       guard_time_ff, guard_time_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // scan bookkeeping
   logic                    sw_found_ff, sw_found_in;
   logic [SW-1:0]           sw_idx_ff, sw_idx_in;
   logic                    cur_found_ff, cur_found_in;
   logic [SW-1:0]           cur_idx_ff, cur_idx_in;
   logic                    stop_ff, stop_in;
   logic [SW-1:0]           best_idx_ff, best_idx_in;
   logic [PRIO_W-1:0]       best_prio_ff, best_prio_in;
   logic                    out_found_ff, out_found_in;
   logic [SW-1:0]           out_idx_ff, out_idx_in;

   // per-item result accumulation
   logic                    sel_v_ff, sel_v_in;
   logic [DEV_W-1:0]        sel_dev_ff, sel_dev_in;
   logic                    spd_v_ff, spd_v_in;
   logic [SPEED_W-1:0]      spd_val_ff, spd_val_in;

   // latched operation
   logic [OPCODE_W-1:0]     op_ff;
   logic [DEV_W-1:0]        dev_ff;
   logic [SPEED_W-1:0]      speed_ff;
   logic [PRIO_W-1:0]       prio_ff;
   logic                    intr_ff;
   logic [TIME_W-1:0]       delta_ff;

   // output register payload
   logic                    rsp_sel_v_ff;
   logic [DEV_W-1:0]        rsp_sel_dev_ff;
   logic                    rsp_spd_v_ff;
   logic [SPEED_W-1:0]      rsp_spd_val_ff;
   logic signed [CUR_W-1:0] rsp_cur_ff;
   logic                    rsp_qcur_ff;
   logic                    rsp_qsw_ff;

   // slot memories, one read and one write port each
   logic [PRIO_W-1:0]       prio_mem [SLOT_COUNT];
   logic [SPEED_W-1:0]      speed_mem [SLOT_COUNT];
   logic [SW-1:0]           prio_addr, spd_addr;
   logic                    prio_we, spd_we;
   logic [PRIO_W-1:0]       prio_rd_ff;
   logic                    prio_ok_ff;
   logic [SPEED_W-1:0]      spd_rd_ff;
   logic                    spd_ok_ff;
   logic [PRIO_W-1:0]       prio_q;
   logic [SPEED_W-1:0]      spd_q;

   logic                    req_xfer, rsp_load;
   logic [SW-1:0]           dev_idx, scan_idx, prev_idx, start_idx;
   logic                    in_range, dev_ok;
   logic                    take_over;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign dev_idx   = SW'(dev_ff);
   assign in_range  = LW'(dev_ff) < SLOT_LIM;
   assign dev_ok    = in_range && valid_ff[dev_idx];
   assign scan_idx  = SW'(cnt_ff);
   assign prev_idx  = SW'(cnt_ff - 1'b1);
   // selection starts at the current owner, else at slot 0 even if unregistered
   assign start_idx = cur_found_ff ? cur_idx_ff : '0;

   // entries never written read as their reset values
   assign prio_q = prio_ok_ff ? prio_rd_ff : '0;
   assign spd_q  = spd_ok_ff ? spd_rd_ff : SPEED_RESET;

   assign take_over = valid_ff[best_idx_ff] && (!cur_found_ff || best_idx_ff != cur_idx_ff);

   // memory read addresses follow the sequencer
   always_comb begin
      prio_addr = '0;
      if (state_ff == ST_PLOAD) begin
         prio_addr = start_idx;
      end else if (state_ff == ST_PSCAN && cnt_ff != END_CNT) begin
         prio_addr = scan_idx;
      end
      spd_addr = '0;
      if (state_ff == ST_SRD) begin
         spd_addr = dev_idx;
      end else if (state_ff == ST_PDECIDE) begin
         spd_addr = best_idx_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = '0;
      valid_in      = valid_ff;
      owner_in      = owner_ff;
      switching_in  = switching_ff;
      preempt_in    = preempt_ff;
      prio_set_in   = prio_set_ff;
      spd_set_in    = spd_set_ff;
      guard_in      = guard_ff;
      guard_time_in = guard_time_ff;
      sw_found_in   = sw_found_ff;
      sw_idx_in     = sw_idx_ff;
      cur_found_in  = cur_found_ff;
      cur_idx_in    = cur_idx_ff;
      stop_in       = stop_ff;
      best_idx_in   = best_idx_ff;
      best_prio_in  = best_prio_ff;
      out_found_in  = out_found_ff;
      out_idx_in    = out_idx_ff;
      sel_v_in      = sel_v_ff;
      sel_dev_in    = sel_dev_ff;
      spd_v_in      = spd_v_ff;
      spd_val_in    = spd_val_ff;
      prio_we       = 1'b0;
      spd_we        = 1'b0;
      rsp_load      = 1'b0;
      // output register empties on a transfer
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (csr_valid) begin
         guard_time_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               sel_v_in     = 1'b0;
               sel_dev_in   = '0;
               spd_v_in     = 1'b0;
               spd_val_in   = '0;
               sw_found_in  = 1'b0;
               cur_found_in = 1'b0;
               stop_in      = 1'b0;
               out_found_in = 1'b0;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (op_ff)
               OP_TICK: begin
                  state_in = ST_SSCAN;
               end
               OP_REGISTER: begin
                  if (in_range) begin
                     valid_in[dev_idx] = 1'b1;
                  end
                  state_in = ST_FIND;
               end
               OP_SET_SPEED: begin
                  state_in = dev_ok ? ST_SRD : ST_FIND;
               end
               OP_SET_PRIO: begin
                  if (dev_ok) begin
                     prio_we              = 1'b1;
                     prio_set_in[dev_idx] = 1'b1;
                  end
                  state_in = ST_FIND;
               end
               OP_SET_INTR: begin
                  if (dev_ok) begin
                     preempt_in[dev_idx] = intr_ff;
                  end
                  state_in = ST_FIND;
               end
               OP_QUERY: begin
                  state_in = ST_FIND;
               end
               default: begin
                  state_in = ST_FIND;
               end
            endcase
         end
         ST_SSCAN: begin
            // highest switching slot, and the owner walk with its early stop
            if (valid_ff[scan_idx] && switching_ff[scan_idx]) begin
               sw_found_in = 1'b1;
               sw_idx_in   = scan_idx;
            end
            if (!stop_ff && valid_ff[scan_idx] && owner_ff[scan_idx]) begin
               cur_found_in = 1'b1;
               cur_idx_in   = scan_idx;
               if (!preempt_ff[scan_idx]) begin
                  stop_in = 1'b1;
               end
            end
            if (cnt_ff == LAST_CNT) begin
               state_in = ST_STICK;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_STICK: begin
            if (sw_found_ff) begin
               if (guard_ff[GUARD_W-1] || guard_ff == '0) begin
                  switching_in[sw_idx_ff] = 1'b0;
                  owner_in[sw_idx_ff]     = 1'b1;
               end else begin
                  guard_in = guard_ff - $signed({2'b00, delta_ff});
               end
               state_in = ST_FIND;
            end else if (stop_ff) begin
               // owner cannot be preempted
               state_in = ST_FIND;
            end else begin
               best_idx_in = start_idx;
               state_in    = ST_PLOAD;
            end
         end
         ST_PLOAD: begin
            state_in = ST_PSCAN;
         end
         ST_PSCAN: begin
            // read data is registered, so it belongs to the previous address
            if (cnt_ff == '0) begin
               best_prio_in = prio_q;
            end else if (valid_ff[prev_idx] && prio_q > best_prio_ff) begin
               best_idx_in  = prev_idx;
               best_prio_in = prio_q;
            end
            if (cnt_ff == END_CNT) begin
               state_in = ST_PDECIDE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_PDECIDE: begin
            if (take_over) begin
               if (cur_found_ff) begin
                  owner_in[cur_idx_ff]     = 1'b0;
                  switching_in[cur_idx_ff] = 1'b0;
               end
               owner_in[best_idx_ff]     = 1'b0;
               switching_in[best_idx_ff] = 1'b1;
               sel_v_in   = 1'b1;
               sel_dev_in = DEV_W'(best_idx_ff);
               guard_in   = $signed({2'b00, guard_time_ff});
               state_in   = ST_PEMIT;
            end else begin
               state_in = ST_FIND;
            end
         end
         ST_PEMIT: begin
            spd_v_in   = 1'b1;
            spd_val_in = spd_q;
            state_in   = ST_FIND;
         end
         ST_SRD: begin
            state_in = ST_SCMP;
         end
         ST_SCMP: begin
            if (spd_q != speed_ff) begin
               spd_we              = 1'b1;
               spd_set_in[dev_idx] = 1'b1;
               if (switching_ff[dev_idx]) begin
                  guard_in   = $signed({2'b00, guard_time_ff});
                  spd_v_in   = 1'b1;
                  spd_val_in = speed_ff;
               end else if (owner_ff[dev_idx]) begin
                  owner_in[dev_idx]     = 1'b0;
                  switching_in[dev_idx] = 1'b1;
                  guard_in   = $signed({2'b00, guard_time_ff});
                  spd_v_in   = 1'b1;
                  spd_val_in = speed_ff;
               end
            end
            state_in = ST_FIND;
         end
         ST_FIND: begin
            // lowest registered current slot
            if (!out_found_ff && valid_ff[scan_idx] && owner_ff[scan_idx]) begin
               out_found_in = 1'b1;
               out_idx_in   = scan_idx;
            end
            if (cnt_ff == LAST_CNT) begin
               state_in = ST_RESP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         valid_ff      <= '0;
         owner_ff      <= '0;
         switching_ff  <= '0;
         preempt_ff    <= '1;
         prio_set_ff   <= '0;
         spd_set_ff    <= '0;
         guard_ff      <= $signed({2'b00, GUARD_RESET_US});
         guard_time_ff <= GUARD_RESET_US;
         rsp_valid_ff  <= 1'b0;
         sw_found_ff   <= 1'b0;
         cur_found_ff  <= 1'b0;
         stop_ff       <= 1'b0;
         out_found_ff  <= 1'b0;
         sel_v_ff      <= 1'b0;
         spd_v_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         valid_ff      <= valid_in;
         owner_ff      <= owner_in;
         switching_ff  <= switching_in;
         preempt_ff    <= preempt_in;
         prio_set_ff   <= prio_set_in;
         spd_set_ff    <= spd_set_in;
         guard_ff      <= guard_in;
         guard_time_ff <= guard_time_in;
         rsp_valid_ff  <= rsp_valid_in;
         sw_found_ff   <= sw_found_in;
         cur_found_ff  <= cur_found_in;
         stop_ff       <= stop_in;
         out_found_ff  <= out_found_in;
         sel_v_ff      <= sel_v_in;
         spd_v_ff      <= spd_v_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      sw_idx_ff    <= sw_idx_in;
      cur_idx_ff   <= cur_idx_in;
      best_idx_ff  <= best_idx_in;
      best_prio_ff <= best_prio_in;
      out_idx_ff   <= out_idx_in;
      sel_dev_ff   <= sel_dev_in;
      spd_val_ff   <= spd_val_in;
      if (req_xfer) begin
         op_ff    <= req_opcode;
         dev_ff   <= req_device;
         speed_ff <= req_speed;
         prio_ff  <= req_priority_req;
         intr_ff  <= req_interruptible;
         delta_ff <= req_delta_us;
      end
      if (rsp_load) begin
         rsp_sel_v_ff   <= sel_v_ff;
         rsp_sel_dev_ff <= sel_dev_ff;
         rsp_spd_v_ff   <= spd_v_ff;
         rsp_spd_val_ff <= spd_val_ff;
         rsp_cur_ff     <= out_found_ff ? $signed(CUR_W'(out_idx_ff)) : '1;
         rsp_qcur_ff    <= dev_ok && owner_ff[dev_idx];
         rsp_qsw_ff     <= dev_ok && switching_ff[dev_idx];
      end
   end

   // slot memories
   always_ff @(posedge clock) begin
      prio_rd_ff <= prio_mem[prio_addr];
      prio_ok_ff <= prio_set_ff[prio_addr];
      if (prio_we) begin
         prio_mem[dev_idx] <= prio_ff;
      end
   end

   always_ff @(posedge clock) begin
      spd_rd_ff <= speed_mem[spd_addr];
      spd_ok_ff <= spd_set_ff[spd_addr];
      if (spd_we) begin
         speed_mem[dev_idx] <= speed_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_mux_select_valid  = rsp_sel_v_ff;
   assign rsp_mux_select_device = rsp_sel_dev_ff;
   assign rsp_speed_set_valid   = rsp_spd_v_ff;
   assign rsp_speed_value       = rsp_spd_val_ff;
   assign rsp_current_device    = rsp_cur_ff;
   assign rsp_queried_current   = rsp_qcur_ff;
   assign rsp_queried_switching = rsp_qsw_ff;

   // a slot is never current and being switched to at once
   `SPS_ASSERT_IMP(a_owner_excl_switch, 1'b1, (owner_ff & switching_ff) == '0,
      "slot both current and switching")
   // an accepted transfer starts decoding next cycle
   `SPS_ASSERT_NXT(a_accept_to_exec, req_xfer, state_ff == ST_EXEC,
      "accepted transfer not decoded")
   // a mux select always comes with a speed command
   `SPS_ASSERT_IMP(a_select_has_speed, rsp_valid && rsp_mux_select_valid,
      rsp_speed_set_valid, "select without speed command")
   // a finished result lands in the output register
   `SPS_ASSERT_NXT(a_resp_loads, state_ff == ST_RESP && (!rsp_valid_ff || !rsp_stall),
      rsp_valid_ff && state_ff == ST_IDLE, "result not presented")

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for shared_port_priority_switcher_top
// depends on sps_pkg and the rtl top; runs directed then random operations against
// an in-bench prediction of slot arbitration, guard countdown and mux/speed commands
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sps_pkg::*;

   localparam int CLK_PERIOD       = 8;
   localparam int SLOT_N           = SLOT_COUNT_DEFAULT;
   // slowest operation is a tick: three slot passes plus overhead
   localparam int SETTLE_CYCLES    = 3 * SLOT_N + 20;
   localparam int RANDOM_PER_PHASE = 110;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_LIMIT      = 20000;
   localparam int TIMEOUT_NS       = 5000000;
   localparam int GUARD_MAX_US     = 1000000;

   // opcodes the block does not define; they behave as queries
   localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

   localparam logic [SPEED_W-1:0] SPEED_ALT = 24'd115200;
   localparam logic [CUR_W-1:0]   NO_OWNER  = 5'h1f;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [DEV_W-1:0]    device;
      logic [SPEED_W-1:0]  speed;
      logic [PRIO_W-1:0]   prio;
      logic                intr;
      logic [TIME_W-1:0]   delta;
   } port_op_type;

   typedef struct packed {
      logic               sel_valid;
      logic [DEV_W-1:0]   sel_dev;
      logic               spd_valid;
      logic [SPEED_W-1:0] spd;
      logic [CUR_W-1:0]   cur;
      logic               q_cur;
      logic               q_sw;
   } port_result_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #(CLK_PERIOD / 2) clock = ~clock;

   // block ports, all driven to known values from time zero
   logic                    req_valid         = 1'b0;
   logic                    req_stall;
   logic [OPCODE_W-1:0]     req_opcode        = '0;
   logic [DEV_W-1:0]        req_device        = '0;
   logic [SPEED_W-1:0]      req_speed         = '0;
   logic [PRIO_W-1:0]       req_priority_req  = '0;
   logic                    req_interruptible = 1'b0;
   logic [TIME_W-1:0]       req_delta_us      = '0;
   logic                    rsp_valid;
   logic                    rsp_stall         = 1'b0;
   logic                    rsp_mux_select_valid;
   logic [DEV_W-1:0]        rsp_mux_select_device;
   logic                    rsp_speed_set_valid;
   logic [SPEED_W-1:0]      rsp_speed_value;
   logic signed [CUR_W-1:0] rsp_current_device;
   logic                    rsp_queried_current;
   logic                    rsp_queried_switching;
   logic                    csr_valid         = 1'b0;
   logic                    csr_ready;
   logic [TIME_W-1:0]       csr_data          = '0;

   shared_port_priority_switcher_top #(.SLOT_COUNT(SLOT_N)) uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_opcode            (req_opcode),
      .req_device            (req_device),
      .req_speed             (req_speed),
      .req_priority_req      (req_priority_req),
      .req_interruptible     (req_interruptible),
      .req_delta_us          (req_delta_us),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_mux_select_valid  (rsp_mux_select_valid),
      .rsp_mux_select_device (rsp_mux_select_device),
      .rsp_speed_set_valid   (rsp_speed_set_valid),
      .rsp_speed_value       (rsp_speed_value),
      .rsp_current_device    (rsp_current_device),
      .rsp_queried_current   (rsp_queried_current),
      .rsp_queried_switching (rsp_queried_switching),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_data              (csr_data)
   );

   // operations waiting to be offered, and results the block still owes us
   port_op_type     op_backlog[$];
   port_result_type pending_results[$];

   // idle rates in percent, changed only between phases
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // long receiver hold-off
   bit   hold_go  = 1'b0;
   logic hold_rsp = 1'b0;

   int error_count    = 0;
   int transfer_count = 0;
   int select_count   = 0;
   int speed_count    = 0;
   int setting_count  = 0;

   // mirror of the slot table and guard timing
   logic               slot_used     [SLOT_N];
   logic [PRIO_W-1:0]  slot_prio     [SLOT_N];
   logic               slot_preempt  [SLOT_N];
   logic [SPEED_W-1:0] slot_baud     [SLOT_N];
   logic               slot_settling [SLOT_N];
   logic               slot_holds    [SLOT_N];
   logic [TIME_W-1:0]  guard_setting;
   int                 guard_left;

   function automatic void clear_slot_table();
      for (int i = 0; i < SLOT_N; i++) begin
         slot_used[i]     = 1'b0;
         slot_prio[i]     = '0;
         slot_preempt[i]  = 1'b1;
         slot_baud[i]     = SPEED_RESET;
         slot_settling[i] = 1'b0;
         slot_holds[i]    = 1'b0;
      end
      guard_setting = GUARD_RESET_US;
      guard_left    = int'(GUARD_RESET_US);
   endfunction

   // pick a new owner when nobody is settling; a non-preemptable holder blocks it
   function automatic void arbitrate(ref port_result_type r);
      int  holder;
      int  best;
      bit  locked;
      holder = -1;
      best   = 0;
      locked = 1'b0;
      for (int i = 0; i < SLOT_N; i++) begin
         if (!locked && slot_used[i] && slot_holds[i]) begin
            best   = i;
            holder = i;
            if (!slot_preempt[i]) locked = 1'b1;
         end
      end
      if (locked) return;
      // candidate starts at the holder, else at slot 0 even if it was never registered
      for (int i = 0; i < SLOT_N; i++) begin
         if (slot_used[i] && slot_prio[i] > slot_prio[best]) best = i;
      end
      if (best != holder && slot_used[best]) begin
         if (holder >= 0) begin
            slot_holds[holder]    = 1'b0;
            slot_settling[holder] = 1'b0;
         end
         slot_holds[best]    = 1'b0;
         slot_settling[best] = 1'b1;
         r.sel_valid = 1'b1;
         r.sel_dev   = DEV_W'(best);
         r.spd_valid = 1'b1;
         r.spd       = slot_baud[best];
         guard_left  = int'(guard_setting);
      end
   endfunction

   function automatic port_result_type predict_port_result(port_op_type op);
      port_result_type r;
      int              dev;
      int              settling;
      r   = '0;
      dev = int'(op.device);
      r.cur = NO_OWNER;
      if (op.opcode == OP_TICK) begin
         // the highest settling slot is the one the tick acts on
         settling = -1;
         for (int i = 0; i < SLOT_N; i++)
            if (slot_used[i] && slot_settling[i]) settling = i;
         if (settling >= 0) begin
            if (guard_left <= 0) begin
               slot_settling[settling] = 1'b0;
               slot_holds[settling]    = 1'b1;
            end else begin
               guard_left -= int'(op.delta);
            end
         end else begin
            arbitrate(r);
         end
      end else if (op.opcode == OP_REGISTER) begin
         slot_used[dev] = 1'b1;
      end else if (slot_used[dev]) begin
         case (op.opcode)
            OP_SET_SPEED: begin
               if (slot_baud[dev] != op.speed) begin
                  slot_baud[dev] = op.speed;
                  if (slot_settling[dev]) begin
                     guard_left  = int'(guard_setting);
                     r.spd_valid = 1'b1;
                     r.spd       = op.speed;
                  end else if (slot_holds[dev]) begin
                     // owner goes back through the guard time at the new rate
                     slot_holds[dev]    = 1'b0;
                     slot_settling[dev] = 1'b1;
                     guard_left  = int'(guard_setting);
                     r.spd_valid = 1'b1;
                     r.spd       = op.speed;
                  end
               end
            end
            OP_SET_PRIO: slot_prio[dev] = op.prio;
            OP_SET_INTR: slot_preempt[dev] = op.intr;
            default: ;
         endcase
      end
      for (int i = SLOT_N - 1; i >= 0; i--)
         if (slot_used[i] && slot_holds[i]) r.cur = CUR_W'(i);
      if (slot_used[dev]) begin
         r.q_cur = slot_holds[dev];
         r.q_sw  = slot_settling[dev];
      end
      return r;
   endfunction

   // operation driver: holds a stalled transfer, otherwise offers the next one or idles
   always @(posedge clock) begin : drive_ops
      port_op_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (op_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            nxt = op_backlog.pop_front();
            req_valid         <= 1'b1;
            req_opcode        <= nxt.opcode;
            req_device        <= nxt.device;
            req_speed         <= nxt.speed;
            req_priority_req  <= nxt.prio;
            req_interruptible <= nxt.intr;
            req_delta_us      <= nxt.delta;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side back-pressure, random or forced by the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_rsp || ($urandom_range(99, 0) < recv_idle_pct);
      end
   end

   // long hold-off counted here so the sender keeps offering while the block fills up
   initial begin : long_hold
      wait (hold_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // monitor: check result transfers first, then predict for the accepted operation
   always @(posedge clock) begin : watch_ports
      port_op_type     seen;
      port_result_type want;
      port_result_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_mux_select_valid, rsp_mux_select_device, rsp_speed_set_valid,
                    rsp_speed_value, rsp_current_device, rsp_queried_current,
                    rsp_queried_switching};
            if (pending_results.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: result transfer with no operation outstanding", $realtime);
            end else begin
               want = pending_results.pop_front();
               if (got.sel_valid !== want.sel_valid || got.sel_dev !== want.sel_dev ||
                   got.spd_valid !== want.spd_valid || got.spd !== want.spd ||
                   got.cur !== want.cur || got.q_cur !== want.q_cur ||
                   got.q_sw !== want.q_sw) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("%0t: mismatch  sel %b/%0d spd %b/%0d cur %0d q %b%b", $realtime,
                              want.sel_valid, want.sel_dev, want.spd_valid, want.spd,
                              $signed(want.cur), want.q_cur, want.q_sw);
                     $display("        actual  sel %b/%0d spd %b/%0d cur %0d q %b%b",
                              got.sel_valid, got.sel_dev, got.spd_valid, got.spd,
                              $signed(got.cur), got.q_cur, got.q_sw);
                  end
               end
               if (got.sel_valid === 1'b1) select_count++;
               if (got.spd_valid === 1'b1) speed_count++;
            end
         end
         if (req_valid && !req_stall) begin
            seen = '{req_opcode, req_device, req_speed, req_priority_req,
                     req_interruptible, req_delta_us};
            pending_results.push_back(predict_port_result(seen));
            transfer_count++;
         end
      end
   end

   function automatic void push_op(logic [OPCODE_W-1:0] opc, logic [DEV_W-1:0] dev,
                                   logic [SPEED_W-1:0] spd, logic [PRIO_W-1:0] pri,
                                   logic itr, logic [TIME_W-1:0] dly);
      op_backlog.push_back('{opc, dev, spd, pri, itr, dly});
   endfunction

   // random operation: mostly register/configure/tick on a few busy slots
   function automatic port_op_type random_op();
      port_op_type op;
      int          pick;
      op.device = DEV_W'($urandom_range(SLOT_N - 1, 0));
      op.speed  = SPEED_W'($urandom);
      op.prio   = PRIO_W'($urandom);
      op.intr   = 1'($urandom);
      op.delta  = TIME_W'($urandom_range(GUARD_MAX_US, 0));
      pick = int'($urandom_range(99, 0));
      if (pick < 10)      op.opcode = OP_REGISTER;
      else if (pick < 22) op.opcode = OP_SET_SPEED;
      else if (pick < 36) op.opcode = OP_SET_PRIO;
      else if (pick < 44) op.opcode = OP_SET_INTR;
      else if (pick < 84) op.opcode = OP_TICK;
      else if (pick < 95) op.opcode = OP_QUERY;
      else if (pick < 98) op.opcode = OP_SPARE_6;
      else                op.opcode = OP_SPARE_7;
      // slot 0 stays rare so the unregistered-slot-0 case keeps mattering
      if ($urandom_range(3, 0) != 0) op.device = DEV_W'($urandom_range(7, 1));
      // familiar rates make repeated speeds likely
      case ($urandom_range(2, 0))
         0: op.speed = SPEED_RESET;
         1: op.speed = SPEED_ALT;
         default: ;
      endcase
      // tick lengths around the guard time so switches do settle
      case ($urandom_range(3, 0))
         0: op.delta = '0;
         1: op.delta = TIME_W'($urandom_range(5000, 1));
         2: op.delta = guard_setting;
         default: ;
      endcase
      return op;
   endfunction

   // wait until nothing is offered or owed, bounded
   task automatic wait_quiet();
      int spent;
      spent = 0;
      do begin
         @(posedge clock);
         spent++;
      end while (!(op_backlog.size() == 0 && !req_valid && pending_results.size() == 0)
                 && spent < DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_guard(logic [TIME_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      guard_setting = value;
      setting_count++;
   endtask

   initial begin : stimulus
      logic [TIME_W-1:0] guard_plan[4];
      clear_slot_table();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part, sender idles a third of the time, receiver two thirds
      send_idle_pct = 33;
      recv_idle_pct = 67;
      write_guard(GUARD_RESET_US);
      push_op(OP_TICK,      4'd0,  '0,         '0,     1'b0, 20'd100);  // nothing registered
      push_op(OP_QUERY,     4'd15, 24'hffffff, 8'hff,  1'b1, 20'd1000000);
      push_op(OP_REGISTER,  4'd5,  '0,         '0,     1'b0, '0);
      push_op(OP_TICK,      4'd0,  '0,         '0,     1'b0, '0);  // unregistered slot 0 blocks
      push_op(OP_SET_PRIO,  4'd5,  '0,         8'hff,  1'b0, '0);
      push_op(OP_SET_SPEED, 4'd5,  24'hffffff, '0,     1'b0, '0);
      push_op(OP_TICK,      4'd5,  '0,         '0,     1'b0, 20'd1);  // slot 5 selected
      push_op(OP_SET_SPEED, 4'd5,  24'hffffff, '0,     1'b0, '0);  // same speed
      push_op(OP_SET_SPEED, 4'd5,  24'd0,      '0,     1'b0, '0);  // speed while settling
      push_op(OP_TICK,      4'd5,  '0,         '0,     1'b0, 20'd1000000);
      push_op(OP_TICK,      4'd5,  '0,         '0,     1'b0, '0);  // slot 5 takes ownership
      push_op(OP_QUERY,     4'd5,  '0,         '0,     1'b0, '0);
      push_op(OP_SET_INTR,  4'd5,  '0,         '0,     1'b0, '0);
      push_op(OP_SET_PRIO,  4'd5,  '0,         8'd10,  1'b0, '0);
      push_op(OP_REGISTER,  4'd9,  '0,         '0,     1'b0, '0);
      push_op(OP_SET_PRIO,  4'd9,  '0,         8'd200, 1'b0, '0);
      push_op(OP_TICK,      4'd9,  '0,         '0,     1'b0, 20'd10);  // owner not preemptable
      push_op(OP_SET_INTR,  4'd5,  '0,         '0,     1'b1, '0);
      push_op(OP_TICK,      4'd9,  '0,         '0,     1'b0, 20'd10);  // slot 9 preempts
      push_op(OP_REGISTER,  4'd9,  '0,         '0,     1'b0, '0);  // second registration
      push_op(OP_SET_SPEED, 4'd3,  SPEED_ALT,  '0,     1'b0, '0);  // unregistered slot
      push_op(OP_SET_INTR,  4'd2,  '0,         '0,     1'b0, '0);
      push_op(OP_SPARE_6,   4'd9,  '0,         '0,     1'b0, '0);
      push_op(OP_SPARE_7,   4'd15, '0,         '0,     1'b0, '0);
      push_op(OP_TICK,      4'd0,  '0,         '0,     1'b0, '0);  // zero-length tick
      wait_quiet();

      // random phases over the guard extremes and two in-between settings
      guard_plan[0] = '0;
      guard_plan[1] = TIME_W'(GUARD_MAX_US);
      guard_plan[2] = TIME_W'($urandom_range(GUARD_MAX_US - 1, 1));
      guard_plan[3] = TIME_W'($urandom_range(20000, 1));
      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 67;
            recv_idle_pct = 33;
         end else if (phase == 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_guard(guard_plan[phase]);
         repeat (RANDOM_PER_PHASE) op_backlog.push_back(random_op());
         // in the idle-free phase the result side is held off to fill the block
         if (phase == 3) hold_go = 1'b1;
         wait_quiet();
      end

      if (pending_results.size() != 0) begin
         error_count++;
         $display("%0d results never arrived", pending_results.size());
      end
      $display("covered %0d transfers over %0d guard settings:", transfer_count, setting_count);
      $display("%0d mux selects, %0d speed commands, %0d mismatches and stray results",
               select_count, speed_count, error_count);
      if (error_count == 0) begin
         $display("** shared_port_priority_switcher_top: PASSED **");
      end else begin
         $display("** shared_port_priority_switcher_top: FAILED **");
      end
      $finish;
   end

   // hang guard
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("** shared_port_priority_switcher_top: FAILED **");
      $finish;
   end

endmodule
